/* hdl/sam_pkg.sv */
// scoped address map: shared types, codes and default sizes
// no dependencies; imported by scoped_address_map_core
package sam_pkg;

  localparam int ADDR_W       = 48;
  localparam int DEV_W        = 8;
  localparam int CAP_W        = 9;
  localparam int REQ_W        = 3;
  localparam int STATUS_W     = 3;
  localparam int LEVEL_W      = 5;
  localparam int ENTRY_COUNT_DEF = 256;
  localparam int SCOPE_COUNT_DEF = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT        = 3'd0,
    REQ_LOOKUP_ANY = 3'd1,
    REQ_LOOKUP_CUR = 3'd2,
    REQ_PUSH       = 3'd3,
    REQ_POP        = 3'd4
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_POOL_FULL = 3'd2,
    ST_NO_SCOPE  = 3'd3,
    ST_NO_ROOM   = 3'd4
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] host;
    logic [ADDR_W-1:0] daddr;
    logic [DEV_W-1:0]  dev;
  } entry_t;

endpackage

/* hdl/scoped_address_map_core.sv */
// scoped address map: stack of scopes mapping host to device addresses
// depends on sam_pkg; entry store and scope table are local memories
//
// Usage: drive in_* and raise start while busy is low; that beat is taken.
// busy stays high until the result; the result shows on out_* for exactly
// one cycle with out_valid high, and the receiver cannot hold it off.
// Every request gives one result beat.
// Put, push, pop, failed requests and empty lookups go through the scope
// table read, then execute. A lookup walks the entry memory newest first,
// one entry per cycle through the registered read port, examining up to
// ENTRY_COUNT entries; the walk sets the throughput.
// One request is in flight at a time.
// Reset (rst_n low, synchronous) closes all scopes and empties the entry
// pool; memory contents are not cleared and no clearing pass is needed.
module scoped_address_map_core
  #(
  parameter int ENTRY_COUNT = sam_pkg::ENTRY_COUNT_DEF,
  parameter int SCOPE_COUNT = sam_pkg::SCOPE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [sam_pkg::REQ_W-1:0]     in_req_type,
  input  logic [sam_pkg::ADDR_W-1:0]    in_host_address,
  input  logic [sam_pkg::ADDR_W-1:0]    in_device_address,
  input  logic [sam_pkg::DEV_W-1:0]     in_device_number,
  input  logic [sam_pkg::CAP_W-1:0]     in_scope_capacity,
  output logic                          out_valid,
  output logic [sam_pkg::STATUS_W-1:0]  out_status,
  output logic [sam_pkg::ADDR_W-1:0]    out_found_address,
  output logic [sam_pkg::LEVEL_W-1:0]   out_scope_level
);
  import sam_pkg::*;

  localparam int AW  = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int CW  = $clog2(ENTRY_COUNT + 1);
  localparam int SAW = (SCOPE_COUNT > 1) ? $clog2(SCOPE_COUNT) : 1;
  localparam int SCW = $clog2(SCOPE_COUNT + 1);
  localparam int PW  = ((CW > CAP_W) ? CW : CAP_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCOPE  = 4'b0010,
    S_EXEC   = 4'b0100,
    S_SEARCH = 4'b1000
  } state_t;

  // entries keep the device id of their scope, captured at push time
  typedef struct packed {
    logic [CW-1:0]    base;
    logic [CW-1:0]    limit;
    logic [DEV_W-1:0] dev;
  } scope_t;

  entry_t entry_mem [ENTRY_COUNT];
  scope_t scope_mem [SCOPE_COUNT];

  state_t             state_r;
  logic [CW-1:0]      used_r;
  logic [SCW-1:0]     open_r;
  logic [REQ_W-1:0]   req_r;
  logic [ADDR_W-1:0]  host_r;
  logic [ADDR_W-1:0]  daddr_r;
  logic [DEV_W-1:0]   dev_r;
  logic [CAP_W-1:0]   cap_r;
  scope_t             scope_rd_r;
  entry_t             entry_rd_r;
  logic [AW-1:0]      ptr_r;
  logic [AW-1:0]      chk_idx_r;
  logic               chk_v_r;
  logic [CW-1:0]      low_r;
  logic [SAW-1:0]     top;
  logic               hit;
  logic               at_low;
  logic               room_bad;

  assign busy     = (state_r != S_IDLE);
  assign top      = SAW'(open_r - SCW'(1));
  assign hit      = chk_v_r && (entry_rd_r.host == host_r) && (entry_rd_r.dev == dev_r);
  assign at_low   = (CW'(chk_idx_r) == low_r);
  assign room_bad = (PW'(ENTRY_COUNT) - PW'(used_r)) < PW'(cap_r);

  always_ff @(posedge clk) begin
    scope_rd_r <= scope_mem[top];
    entry_rd_r <= entry_mem[ptr_r];
    chk_idx_r  <= ptr_r;
    if (state_r == S_EXEC && req_r == REQ_PUSH && !(open_r >= SCW'(SCOPE_COUNT)) &&
        !room_bad) begin
      scope_mem[SAW'(open_r)] <= '{base: used_r, limit: CW'(PW'(used_r) + PW'(cap_r)),
                                   dev: dev_r};
    end
    if (state_r == S_EXEC && req_r == REQ_PUT && open_r != '0 &&
        !(used_r >= scope_rd_r.limit || used_r >= CW'(ENTRY_COUNT))) begin
      entry_mem[AW'(used_r)] <= '{host: host_r, daddr: daddr_r, dev: scope_rd_r.dev};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      used_r    <= '0;
      open_r    <= '0;
      out_valid <= 1'b0;
      chk_v_r   <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r   <= in_req_type;
            host_r  <= in_host_address;
            daddr_r <= in_device_address;
            dev_r   <= in_device_number;
            cap_r   <= in_scope_capacity;
            state_r <= S_SCOPE;
          end
        end
        S_SCOPE: begin
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          out_found_address <= '0;
          out_status        <= ST_OK;
          out_scope_level   <= LEVEL_W'(open_r);
          out_valid         <= 1'b1;
          state_r           <= S_IDLE;
          case (req_r)
            REQ_PUT: begin
              if (open_r == '0) begin
                out_status <= ST_NO_SCOPE;
              end else if (used_r >= scope_rd_r.limit || used_r >= CW'(ENTRY_COUNT)) begin
                out_status <= ST_POOL_FULL;
              end else begin
                used_r            <= used_r + CW'(1);
                out_found_address <= daddr_r;
              end
            end
            REQ_LOOKUP_ANY, REQ_LOOKUP_CUR: begin
              if (open_r == '0) begin
                out_status <= ST_NO_SCOPE;
              end else begin
                low_r <= (req_r == REQ_LOOKUP_CUR) ? scope_rd_r.base : '0;
                if (used_r == ((req_r == REQ_LOOKUP_CUR) ? scope_rd_r.base : '0)) begin
                  out_status <= ST_NOT_FOUND;
                end else begin
                  out_valid <= 1'b0;
                  ptr_r     <= AW'(used_r - CW'(1));
                  chk_v_r   <= 1'b0;
                  state_r   <= S_SEARCH;
                end
              end
            end
            REQ_PUSH: begin
              if (open_r >= SCW'(SCOPE_COUNT) || room_bad) begin
                out_status <= ST_NO_ROOM;
              end else begin
                open_r          <= open_r + SCW'(1);
                out_scope_level <= LEVEL_W'(open_r + SCW'(1));
              end
            end
            REQ_POP: begin
              if (open_r == '0) begin
                out_status <= ST_NO_SCOPE;
              end else begin
                used_r          <= scope_rd_r.base;
                open_r          <= open_r - SCW'(1);
                out_scope_level <= LEVEL_W'(open_r - SCW'(1));
              end
            end
            default: begin
            end
          endcase
        end
        S_SEARCH: begin
          chk_v_r <= 1'b1;
          if (CW'(ptr_r) != low_r) begin
            ptr_r <= ptr_r - AW'(1);
          end
          if (hit || (chk_v_r && at_low)) begin
            chk_v_r           <= 1'b0;
            out_valid         <= 1'b1;
            out_status        <= hit ? ST_OK : ST_NOT_FOUND;
            out_found_address <= hit ? entry_rd_r.daddr : '0;
            out_scope_level   <= LEVEL_W'(open_r);
            state_r           <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without a request in flight");

  a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
    open_r <= SCW'(SCOPE_COUNT))
    else $error("open scope count past scope table depth");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(ENTRY_COUNT))
    else $error("entry count past entry store depth");

  a_search_has_scope: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> (open_r != '0))
    else $error("entry walk with no open scope");

  a_search_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |=> $stable(used_r) && $stable(open_r))
    else $error("pool changed during entry walk");

endmodule
